// ===== hw/rtl/fastq_two_bit_base_packer_core_defines.svh =====
// Assertion macros for the packer checker file.
`ifndef FASTQ_TWO_BIT_BASE_PACKER_CORE_DEFINES_SVH
`define FASTQ_TWO_BIT_BASE_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define FTBP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ftbp assertion failed");

// Next-cycle implication, disabled while reset is active.
`define FTBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ftbp assertion failed");

`endif

// ===== hw/rtl/ftbp_pkg.sv =====
// Types, constants and helpers shared by the base packer modules.
`timescale 1ns / 1ps
`default_nettype none

package ftbp_pkg;

  // Stream characters of interest
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharT       = 8'h54;
  localparam logic [7:0] CharG       = 8'h47;
  localparam logic [7:0] CharC       = 8'h43;

  // Base codes
  localparam logic [1:0] CodeA = 2'd0;
  localparam logic [1:0] CodeT = 2'd1;
  localparam logic [1:0] CodeG = 2'd2;
  localparam logic [1:0] CodeC = 2'd3;

  localparam logic [1:0] LastSlot  = 2'd3;
  localparam logic [2:0] FullCount = 3'd4;

  // Two-entry queues between stages
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [1:0] {
    PhaseHeader   = 2'd0,
    PhaseSequence = 2'd1,
    PhasePlus     = 2'd2,
    PhaseQuality  = 2'd3
  } phase_e;

  // Classified sequence-line request
  typedef struct packed {
    logic       is_eol;
    logic [1:0] code;
  } op_t;

  // Request from the front to the command queue
  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_req_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic [2:0] code_count;
    logic       end_of_read;
  } res_t;

  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    case (ch)
      CharT:   code = CodeT;
      CharG:   code = CodeG;
      CharC:   code = CodeC;
      default: code = CodeA;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fastq_two_bit_base_packer_core.sv =====
// Top level of the FASTQ two-bit base packer.
//
// Takes one raw FASTQ byte per request and tracks header, sequence, plus and
// quality lines. Sequence bases are coded T=1, G=2, C=3, anything else 0, and
// packed four to a byte, first base in the low bits; a full byte comes out with
// code_count 4, and the sequence-line newline flushes the remainder (0..3
// codes, possibly none) with end_of_read set. One byte is accepted every cycle
// while the command queue has room, and results pass through two queues: the
// front writes classified bases into a two-entry command queue, the back packs
// them and writes a two-entry result queue. full_o follows the command queue
// and empty_o the result queue, so stalls on either side are absorbed there.
`timescale 1ns / 1ps
`default_nettype none

module fastq_two_bit_base_packer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output      logic       full_o,
  input  wire logic [7:0] char_in_i,
  output      logic       empty_o,
  input  wire logic       pop_i,
  output      logic [7:0] packed_byte_o,
  output      logic [2:0] code_count_o,
  output      logic       end_of_read_o
);
  import ftbp_pkg::*;

  cmd_req_t cmd_req;
  op_t      cmd_op;
  logic     q_full, q_empty, q_pop;
  res_t     res;

  ftbp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .char_in_i (char_in_i),
    .q_full_i  (q_full),
    .full_o    (full_o),
    .cmd_o     (cmd_req)
  );

  ftbp_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_req),
    .full_o  (q_full),
    .empty_o (q_empty),
    .op_o    (cmd_op),
    .pop_i   (q_pop)
  );

  ftbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .op_i        (cmd_op),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty_o),
    .res_o       (res),
    .pop_i       (pop_i)
  );

  assign packed_byte_o = res.packed_byte;
  assign code_count_o  = res.code_count;
  assign end_of_read_o = res.end_of_read;

endmodule

`default_nettype wire

// ===== hw/rtl/ftbp_front.sv =====
// Front end: tracks the FASTQ line phase and classifies sequence-line bytes.
`timescale 1ns / 1ps
`default_nettype none

module ftbp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [7:0]        char_in_i,
  input  wire logic              q_full_i,
  output      logic              full_o,
  output      ftbp_pkg::cmd_req_t cmd_o
);
  import ftbp_pkg::*;

  phase_e phase_q, phase_d;
  logic   accept;
  logic   is_nl;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;
  assign is_nl  = (char_in_i == CharNewline);

  // Forward only sequence-line bytes to the back end
  always_comb begin
    cmd_o.valid     = accept && (phase_q == PhaseSequence);
    cmd_o.op.is_eol = is_nl;
    cmd_o.op.code   = base_code(char_in_i);
  end

  // Advance the phase on every accepted newline
  always_comb begin
    phase_d = phase_q;
    if (accept && is_nl) begin
      phase_d = phase_e'(2'(phase_q + 2'd1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseHeader;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ftbp_cmd_fifo.sv =====
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module ftbp_cmd_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ftbp_pkg::cmd_req_t cmd_i,
  output      logic               full_o,
  output      logic               empty_o,
  output      ftbp_pkg::op_t      op_o,
  input  wire logic               pop_i
);
  import ftbp_pkg::*;

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = cmd_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i.op;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ftbp_back.sv =====
// Back end: packs base codes into bytes and queues the finished results.
`timescale 1ns / 1ps
`default_nettype none

module ftbp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_empty_i,
  input  wire ftbp_pkg::op_t op_i,
  output      logic          cmd_pop_o,
  output      logic          empty_o,
  output      ftbp_pkg::res_t res_o,
  input  wire logic          pop_i
);
  import ftbp_pkg::*;

  logic [7:0]       pack_q, pack_d;
  logic [1:0]       pend_q, pend_d;
  logic [7:0]       merged;
  logic             take;
  logic             res_push;
  res_t             res_new;

  res_t             rmem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             res_full, res_pop;

  assign res_full  = (cnt_q == QCntW'(QDepth));
  assign take      = !cmd_empty_i && !res_full;
  assign cmd_pop_o = take;
  assign merged    = pack_q | (8'(op_i.code) << {pend_q, 1'b0});

  // Pack a code or flush on the end of the sequence line
  always_comb begin
    pack_d   = pack_q;
    pend_d   = pend_q;
    res_push = 1'b0;
    res_new  = '{packed_byte: merged, code_count: FullCount, end_of_read: 1'b0};
    if (take) begin
      if (op_i.is_eol) begin
        res_push = 1'b1;
        res_new  = '{packed_byte: pack_q, code_count: {1'b0, pend_q}, end_of_read: 1'b1};
        pack_d   = '0;
        pend_d   = '0;
      end else if (pend_q == LastSlot) begin
        res_push = 1'b1;
        pack_d   = '0;
        pend_d   = '0;
      end else begin
        pack_d = merged;
        pend_d = pend_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q <= '0;
      pend_q <= '0;
    end else begin
      pack_q <= pack_d;
      pend_q <= pend_d;
    end
  end

  // Result queue
  assign empty_o = (cnt_q == '0);
  assign res_o   = rmem_q[rd_ptr_q];
  assign res_pop = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rmem_q[wr_ptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (res_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (res_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (res_push && !res_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (res_pop && !res_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ftbp_checker.sv =====
// Port-level checker for the base packer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "fastq_two_bit_base_packer_core_defines.svh"

module ftbp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty_o,
  input wire logic       pop_i,
  input wire logic [7:0] packed_byte_o,
  input wire logic [2:0] code_count_o,
  input wire logic       end_of_read_o
);

  // Only a line end may carry a partial byte
  `FTBP_ASSERT_IMPL(a_full_unless_eor, clk_i, rst_ni, !empty_o && !end_of_read_o, code_count_o == 3'd4)
  // A line end carries at most three codes
  `FTBP_ASSERT_IMPL(a_eor_partial, clk_i, rst_ni, !empty_o && end_of_read_o, code_count_o <= 3'd3)
  // An empty remainder is an all-zero byte
  `FTBP_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, !empty_o && code_count_o == 3'd0, packed_byte_o == 8'd0)
  // Hold a stalled result
  `FTBP_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty_o && !pop_i, !empty_o && $stable(packed_byte_o))

endmodule

bind fastq_two_bit_base_packer_core ftbp_checker u_ftbp_checker (.*);

`default_nettype wire

// ===== test/tb_fastq_two_bit_base_packer_core.sv =====
// Self-checking testbench for the FASTQ two-bit base packer core.
`timescale 1ns / 1ps

module tb_fastq_two_bit_base_packer_core;
  import ftbp_pkg::*;

  localparam int unsigned WatchdogCycles = 300000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned ReportLimit    = 10;
  localparam int unsigned IdlePct        = 23;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push_i    = 1'b0;
  logic [7:0] char_in_i = 8'h00;
  logic       pop_i     = 1'b0;
  logic       full_o;
  logic       empty_o;
  logic [7:0] packed_byte_o;
  logic [2:0] code_count_o;
  logic       end_of_read_o;

  // Shadow of the packer state
  phase_e     line_shadow   = PhaseHeader;
  logic [7:0] pack_shadow   = 8'h00;
  logic [1:0] codes_held    = 2'd0;
  res_t       packed_due[$];

  int unsigned seq_bytes_sent = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned drain_hold_req = 0;
  int unsigned drain_hold_left = 0;
  bit          send_idle_on   = 1'b1;
  bit          drain_idle_on  = 1'b1;

  fastq_two_bit_base_packer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .char_in_i     (char_in_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .packed_byte_o (packed_byte_o),
    .code_count_o  (code_count_o),
    .end_of_read_o (end_of_read_o)
  );

  always #6 clk_i = ~clk_i;

  // Map one stream byte to its two-bit nucleotide code
  function automatic logic [1:0] nucleotide_code(input logic [7:0] ch);
    if (ch == CharT) return CodeT;
    if (ch == CharG) return CodeG;
    if (ch == CharC) return CodeC;
    return CodeA;
  endfunction

  // Advance the shadow state by one accepted byte and queue any packed result
  function automatic void predict_packer(input logic [7:0] ch);
    res_t r;
    if (line_shadow != PhaseSequence) begin
      if (ch == CharNewline) line_shadow = phase_e'(line_shadow + 2'd1);
    end else begin
      seq_bytes_sent++;
      if (ch == CharNewline) begin
        r.packed_byte = pack_shadow;
        r.code_count  = {1'b0, codes_held};
        r.end_of_read = 1'b1;
        packed_due.push_back(r);
        pack_shadow = 8'h00;
        codes_held  = 2'd0;
        line_shadow = PhasePlus;
      end else begin
        pack_shadow[{codes_held, 1'b0} +: 2] = nucleotide_code(ch);
        if (codes_held == LastSlot) begin
          r.packed_byte = pack_shadow;
          r.code_count  = FullCount;
          r.end_of_read = 1'b0;
          packed_due.push_back(r);
          pack_shadow = 8'h00;
          codes_held  = 2'd0;
        end else begin
          codes_held = codes_held + 2'd1;
        end
      end
    end
  endfunction

  // Offer one byte, with an occasional idle cycle, and hold it until accepted
  task automatic send_char(input logic [7:0] ch);
    while (send_idle_on && $urandom_range(99) < IdlePct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    char_in_i <= ch;
    do @(posedge clk_i); while (full_o);
    predict_packer(ch);
  endtask

  // Send one byte other than newline, drawn from the whole byte range
  task automatic send_junk();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CharNewline) b = ~b;
    send_char(b);
  endtask

  // Send a whole FASTQ record; junk_pct sets the share of odd sequence bytes
  task automatic send_record(input int unsigned seq_max, input int unsigned junk_pct);
    logic [7:0]  bases [4];
    int unsigned seq_len;
    bases = '{"A", "C", "G", "T"};
    seq_len = $urandom_range(seq_max);
    send_char("@");
    repeat ($urandom_range(3)) send_junk();
    send_char(CharNewline);
    repeat (seq_len) begin
      if ($urandom_range(99) < junk_pct) send_junk();
      else send_char(bases[$urandom_range(3)]);
    end
    send_char(CharNewline);
    send_char("+");
    send_char(CharNewline);
    repeat ($urandom_range(3)) send_char(8'($urandom_range(74, 33)));
    send_char(CharNewline);
  endtask

  // Drain results, check each against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (packed_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("unexpected result: byte %h count %0d eor %b",
                     packed_byte_o, code_count_o, end_of_read_o);
        end else begin
          res_t want;
          want = packed_due.pop_front();
          if (packed_byte_o !== want.packed_byte || code_count_o !== want.code_count ||
              end_of_read_o !== want.end_of_read) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("result mismatch: expected byte %h count %0d eor %b, got %h %0d %b",
                       want.packed_byte, want.code_count, want.end_of_read,
                       packed_byte_o, code_count_o, end_of_read_o);
          end
        end
      end
      // Pick up a hold-off order and count it down before popping again
      if (drain_hold_req != 0) begin
        drain_hold_left = drain_hold_req;
        drain_hold_req  = 0;
      end
      if (drain_hold_left != 0) begin
        drain_hold_left--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= !(drain_idle_on && $urandom_range(99) < IdlePct);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > WatchdogCycles) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Walk every line kind, full and partial bytes, empty reads and odd bytes
  task automatic test_directed_lines();
    logic [7:0] stream [$];
    stream = '{8'hFF, 8'h00, CharNewline,
               "T", "G", "C", "A", CharNewline,
               CharNewline, CharNewline, CharNewline,
               CharNewline,
               "T", CharNewline, "C", CharNewline, CharNewline,
               8'hFF, 8'h00, "a", 8'h0D, "N", "C", CharNewline,
               CharNewline, CharNewline};
    foreach (stream[i]) send_char(stream[i]);
  endtask

  // Mostly clean records with random bases and lengths
  task automatic test_random_records();
    while (seq_bytes_sent < 420) send_record(13, 6);
  endtask

  // Raw byte noise with frequent newlines, then resync on clean records
  task automatic test_line_noise();
    repeat (150) begin
      if ($urandom_range(4) == 0) send_char(CharNewline);
      else send_junk();
    end
    repeat (4) send_record(9, 10);
  endtask

  // Hold the result side off while long reads keep arriving
  task automatic test_output_backpressure();
    drain_hold_req = 400;
    repeat (4) send_record(40, 5);
  endtask

  // Run both sides with no idling at all
  task automatic test_full_rate_stretch();
    send_idle_on  = 1'b0;
    drain_idle_on = 1'b0;
    repeat (8) send_record(12, 5);
    send_idle_on  = 1'b1;
    drain_idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_random_records();
    test_line_noise();
    test_output_backpressure();
    test_full_rate_stretch();
    push_i <= 1'b0;
    // Wait out the remaining results, then catch any stray ones
    while (packed_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== fastq_two_bit_base_packer_core.f =====
+incdir+hw/rtl
hw/rtl/ftbp_pkg.sv
hw/rtl/ftbp_front.sv
hw/rtl/ftbp_cmd_fifo.sv
hw/rtl/ftbp_back.sv
hw/rtl/fastq_two_bit_base_packer_core.sv
hw/rtl/ftbp_checker.sv
test/tb_fastq_two_bit_base_packer_core.sv
